// ----- sv/coo_sparse_matrix_vector_multiply_core_defines.svh -----
// Assertion macros shared by the sparse matrix-vector core.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef COO_SPARSE_MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH
`define COO_SPARSE_MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define COO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define COO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/coo_pkg.sv -----
// Types, codes and constants of the COO sparse matrix-vector core.
// Used by coo_front, coo_queue, coo_back and the top level.
package coo_pkg;

    localparam int unsigned COO_VECTOR_SIZE = 1024;
    localparam int unsigned IDX_W           = 10;
    localparam int unsigned VLEN_W          = 11;
    localparam int unsigned VAL_W           = 32;
    localparam int unsigned ACC_W           = 48;
    localparam int unsigned Q_DEPTH         = 4;
    localparam int unsigned Q_PTR_W         = 2;
    localparam int unsigned Q_CNT_W         = 3;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_ACCUM  = 2'd2,
        OP_READ_Y = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_ERROR,
        K_LOAD_X,
        K_LOAD_Y,
        K_ACCUM,
        K_READ
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_RND,
        ST_ACC
    } t_back_state;

    typedef struct packed {
        t_op                    op;
        logic [IDX_W-1:0]       row_index;
        logic [IDX_W-1:0]       col_index;
        logic signed [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic                    status;
        logic [IDX_W-1:0]        y_index;
        logic signed [ACC_W-1:0] y_value;
    } t_result;

    // Classified request; for an error the offending index sits in row_index.
    typedef struct packed {
        t_kind                   kind;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

endpackage

// ----- sv/coo_front.sv -----
// Front end: takes requests, holds the length register, checks indices
// and turns each request into a classified command. Uses coo_pkg.
module coo_front import coo_pkg::*; #(
    parameter int unsigned VECTOR_SIZE = COO_VECTOR_SIZE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    input  logic              i_cfg_valid,
    input  logic [VLEN_W-1:0] i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic              r_valid;
    t_cmd              r_cmd;
    logic [VLEN_W-1:0] r_vlen;
    t_cmd              n_cmd;
    logic              accept;
    logic              row_ok;
    logic              col_ok;

    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_cmd  = r_cmd;

    // An index must lie below both the programmed length and the store depth.
    assign row_ok = ({1'b0, i_item.row_index} < r_vlen) &&
                    (32'(i_item.row_index) < 32'(VECTOR_SIZE));
    assign col_ok = ({1'b0, i_item.col_index} < r_vlen) &&
                    (32'(i_item.col_index) < 32'(VECTOR_SIZE));

    always_comb begin
        n_cmd.row_index = i_item.row_index;
        n_cmd.col_index = i_item.col_index;
        n_cmd.value     = i_item.value;
        n_cmd.kind      = K_ERROR;
        unique case (i_item.op)
            OP_LOAD_X: begin
                if (col_ok) begin
                    n_cmd.kind = K_LOAD_X;
                end else begin
                    n_cmd.row_index = i_item.col_index;
                end
            end
            OP_LOAD_Y: begin
                if (row_ok) begin
                    n_cmd.kind = K_LOAD_Y;
                end
            end
            OP_ACCUM: begin
                // The row is checked first and wins when both are bad.
                if (row_ok && col_ok) begin
                    n_cmd.kind = K_ACCUM;
                end else if (row_ok) begin
                    n_cmd.row_index = i_item.col_index;
                end
            end
            OP_READ_Y: begin
                if (row_ok) begin
                    n_cmd.kind = K_READ;
                end
            end
            default: begin
                n_cmd.kind = K_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vlen  <= VLEN_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_vlen <= i_cfg_data;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- sv/coo_queue.sv -----
// Short command queue between the front end and the execution unit.
// Uses t_cmd and the queue sizing constants from coo_pkg.
module coo_queue import coo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- sv/coo_back.sv -----
// Execution unit: holds the x and y stores and runs one command at a time
// through read, multiply, round and accumulate steps. Uses coo_pkg.
module coo_back import coo_pkg::*; #(
    parameter int unsigned VECTOR_SIZE = COO_VECTOR_SIZE
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int unsigned MEM_DEPTH = (VECTOR_SIZE < 1024) ? VECTOR_SIZE : 1024;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

    logic signed [VAL_W-1:0] x_mem [MEM_DEPTH];
    logic signed [ACC_W-1:0] y_mem [MEM_DEPTH];

    t_back_state             r_state;
    t_back_state             n_state;
    t_cmd                    r_cmd;
    logic signed [VAL_W-1:0] r_x_rd;
    logic signed [ACC_W-1:0] r_y_rd;
    logic signed [63:0]      r_prod;
    logic signed [VAL_W-1:0] r_p;
    logic                    r_strobe;
    t_result                 r_result;

    logic                    n_strobe;
    t_result                 n_result;
    logic                    x_we;
    logic                    y_we;
    logic signed [ACC_W-1:0] y_wdata;
    logic signed [63:0]      rnd_sum;
    logic signed [63:0]      rnd_shift;
    logic signed [VAL_W-1:0] p_sat;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic [ADDR_W-1:0]       row_addr;
    logic [ADDR_W-1:0]       col_addr;

    assign row_addr = r_cmd.row_index[ADDR_W-1:0];
    assign col_addr = r_cmd.col_index[ADDR_W-1:0];
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Round to nearest with ties upward, then clamp to the Q16.16 range.
    always_comb begin
        rnd_sum   = r_prod + 64'sd32768;
        rnd_shift = rnd_sum >>> 16;
        if (rnd_shift > 64'sd2147483647) begin
            p_sat = 32'sh7FFFFFFF;
        end else if (rnd_shift < -64'sd2147483648) begin
            p_sat = 32'sh80000000;
        end else begin
            p_sat = rnd_shift[VAL_W-1:0];
        end
    end

    // Saturating accumulate: the top two sum bits differ only on overflow.
    always_comb begin
        acc_sum = {r_y_rd[ACC_W-1], r_y_rd} + {{(ACC_W+1-VAL_W){r_p[VAL_W-1]}}, r_p};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_cmd.kind == K_ACCUM || r_cmd.kind == K_READ) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                n_state = (r_cmd.kind == K_ACCUM) ? ST_RND : ST_IDLE;
            end
            ST_RND: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop            = 1'b0;
        n_strobe         = 1'b0;
        n_result.status  = STATUS_OK;
        n_result.y_index = r_cmd.row_index;
        n_result.y_value = '0;
        x_we             = 1'b0;
        y_we             = 1'b0;
        y_wdata          = acc_sat;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = i_q_valid;
            end
            ST_EXEC: begin
                case (r_cmd.kind)
                    K_ERROR: begin
                        n_strobe        = 1'b1;
                        n_result.status = STATUS_ERR;
                    end
                    K_LOAD_X: begin
                        x_we = 1'b1;
                    end
                    K_LOAD_Y: begin
                        y_we    = 1'b1;
                        y_wdata = {{(ACC_W-VAL_W){r_cmd.value[VAL_W-1]}}, r_cmd.value};
                    end
                    default: begin
                    end
                endcase
            end
            ST_MUL: begin
                if (r_cmd.kind == K_READ) begin
                    n_strobe         = 1'b1;
                    n_result.y_value = r_y_rd;
                end
            end
            ST_RND: begin
            end
            ST_ACC: begin
                y_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_prod   <= r_cmd.value * r_x_rd;
        r_p      <= p_sat;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // The stores are read every cycle at the current command's addresses;
    // nothing writes them between the read and its use.
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[col_addr] <= r_cmd.value;
        end
        r_x_rd <= x_mem[col_addr];
    end

    always_ff @(posedge i_clk) begin
        if (y_we) begin
            y_mem[row_addr] <= y_wdata;
        end
        r_y_rd <= y_mem[row_addr];
    end

endmodule

// ----- sv/coo_sparse_matrix_vector_multiply_core.sv -----
// Channel   Dir  Handshake                  Payload
// request   in   start / busy               i_item   (t_item)
// result    out  o_result_strobe, 1 cycle   o_result (t_result)
// config    in   i_cfg_valid / o_cfg_ready  i_cfg_data (vector length)
//
// A request is registered and classified by the front end, then queued.
// The execution unit pops a command only from IDLE, then runs a load or an
// error through EXEC, a read on to MUL and an accumulate on to RND and ACC.
// busy rises while the queue is full and a classified request waits.
// Synchronous reset clears control state and sets the vector length to 1024;
// the stores hold garbage until written. Results cannot be stalled.
`include "coo_sparse_matrix_vector_multiply_core_defines.svh"
module coo_sparse_matrix_vector_multiply_core import coo_pkg::*; #(
    parameter int unsigned VECTOR_SIZE = COO_VECTOR_SIZE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_result_strobe,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [VLEN_W-1:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    coo_front #(
        .VECTOR_SIZE(VECTOR_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    coo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    coo_back #(
        .VECTOR_SIZE(VECTOR_SIZE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_strobe  (o_result_strobe),
        .o_result  (o_result)
    );

    `COO_ASSERT_NOW(a_err_value_zero, o_result_strobe && (o_result.status == STATUS_ERR), o_result.y_value == '0, "error result carries a nonzero value")
    `COO_ASSERT_NEXT(a_strobe_spaced, o_result_strobe, !o_result_strobe, "results on consecutive cycles")
    `COO_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into a full queue")
    `COO_ASSERT_NOW(a_no_pop_empty, q_pop, q_valid, "pop from an empty queue")

endmodule

// ----- verif/coo_sparse_matrix_vector_multiply_core_tb.sv -----
// Self-checking testbench for the COO sparse matrix-vector core: directed and random
// requests under several vector lengths, each result checked against a local predictor.
// Depends on coo_pkg and coo_sparse_matrix_vector_multiply_core.
module coo_sparse_matrix_vector_multiply_core_tb import coo_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;

    localparam longint ACC_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO  = -ACC_HI - 1;
    localparam longint PROD_HI = 64'sd2147483647;
    localparam longint PROD_LO = -64'sd2147483648;

    // Holds its own copy of x, y and the vector length and works out the result
    // that each request should produce.
    class spmv_predictor;
        logic signed [VAL_W-1:0] x_mem [COO_VECTOR_SIZE];
        logic signed [ACC_W-1:0] y_mem [COO_VECTOR_SIZE];
        logic [VLEN_W-1:0]       length;
        t_result                 pending_results [$];
        int                      n_fail;

        function new();
            length = VLEN_RESET;
            n_fail = 0;
        endfunction

        function bit in_range(logic [IDX_W-1:0] idx);
            return {1'b0, idx} < length;
        endfunction

        function void set_length(logic [VLEN_W-1:0] len);
            length = len;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_error(logic [IDX_W-1:0] idx);
            t_result r;
            r         = '0;
            r.status  = STATUS_ERR;
            r.y_index = idx;
            pending_results.push_back(r);
        endfunction

        function void take_request(t_item req);
            t_result r;
            longint  prod;
            longint  sum;
            case (req.op)
                OP_LOAD_X: begin
                    if (!in_range(req.col_index)) push_error(req.col_index);
                    else x_mem[req.col_index] = req.value;
                end
                OP_LOAD_Y: begin
                    if (!in_range(req.row_index)) push_error(req.row_index);
                    else y_mem[req.row_index] = {{(ACC_W-VAL_W){req.value[VAL_W-1]}}, req.value};
                end
                OP_ACCUM: begin
                    if (!in_range(req.row_index)) begin
                        push_error(req.row_index);
                    end else if (!in_range(req.col_index)) begin
                        push_error(req.col_index);
                    end else begin
                        // Round half up into Q16.16, clamp to 32 bits, then add with
                        // saturation to the Q32.16 accumulator.
                        prod = (longint'($signed(req.value)) * longint'(x_mem[req.col_index])
                                + 64'sd32768) >>> 16;
                        if (prod > PROD_HI) prod = PROD_HI;
                        if (prod < PROD_LO) prod = PROD_LO;
                        sum = longint'(y_mem[req.row_index]) + prod;
                        if (sum > ACC_HI) sum = ACC_HI;
                        if (sum < ACC_LO) sum = ACC_LO;
                        y_mem[req.row_index] = sum[ACC_W-1:0];
                    end
                end
                default: begin
                    if (!in_range(req.row_index)) begin
                        push_error(req.row_index);
                    end else begin
                        r.status  = STATUS_OK;
                        r.y_index = req.row_index;
                        r.y_value = y_mem[req.row_index];
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d index %0d value %h",
                         $time, got.status, got.y_index, got.y_value);
                n_fail++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                n_fail++;
            end
            if (got.y_index !== want.y_index) begin
                $display("%0t: y_index expected %0d got %0d", $time, want.y_index, got.y_index);
                n_fail++;
            end
            if (got.y_value !== want.y_value) begin
                $display("%0t: y_value expected %h got %h", $time, want.y_value, got.y_value);
                n_fail++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_item             i_item      = '0;
    logic              o_result_strobe;
    t_result           o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [VLEN_W-1:0] i_cfg_data  = '0;

    spmv_predictor model = new();
    int            cycle_count = 0;
    int            cur_len = COO_VECTOR_SIZE;
    bit            no_gaps = 1'b0;
    bit            x_loaded [COO_VECTOR_SIZE];
    bit            y_loaded [COO_VECTOR_SIZE];

    coo_sparse_matrix_vector_multiply_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_strobe) model.match_result(o_result);
            if (start && !busy) model.take_request(i_item);
            if (i_cfg_valid && o_cfg_ready) model.set_length(i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("coo_sparse_matrix_vector_multiply_core_tb NOT OK");
            $finish;
        end
    end

    function automatic bit idx_valid(logic [IDX_W-1:0] idx);
        return int'(idx) < cur_len;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int cap);
        int roll;
        roll = $urandom_range(0, 99);
        if (cap == 0 || roll < 10) return IDX_W'($urandom_range(0, COO_VECTOR_SIZE - 1));
        if (roll < 16 && cap < COO_VECTOR_SIZE) return IDX_W'(cap);
        if (roll < 22) return IDX_W'(cap - 1);
        if (roll < 70) return IDX_W'($urandom_range(0, (cap < 8 ? cap : 8) - 1));
        return IDX_W'($urandom_range(0, cap - 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            2:       return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item make_request();
        t_item req;
        int    cap;
        int    roll;
        bit    row_ok;
        bit    col_ok;
        cap           = (cur_len > COO_VECTOR_SIZE) ? COO_VECTOR_SIZE : cur_len;
        req.row_index = pick_index(cap);
        req.col_index = pick_index(cap);
        req.value     = pick_value();
        roll          = $urandom_range(0, 99);
        if (roll < 15)      req.op = OP_LOAD_X;
        else if (roll < 30) req.op = OP_LOAD_Y;
        else if (roll < 75) req.op = OP_ACCUM;
        else                req.op = OP_READ_Y;
        row_ok = idx_valid(req.row_index);
        col_ok = idx_valid(req.col_index);
        // A valid accumulate or read must only touch entries that hold data, so
        // such a request becomes the load that fills the missing entry.
        if (req.op == OP_ACCUM && row_ok && col_ok && !x_loaded[req.col_index])
            req.op = OP_LOAD_X;
        else if (((req.op == OP_ACCUM && col_ok) || req.op == OP_READ_Y) && row_ok
                 && !y_loaded[req.row_index])
            req.op = OP_LOAD_Y;
        return req;
    endfunction

    task automatic send_request(input t_item req);
        int gap;
        if (req.op == OP_LOAD_X && idx_valid(req.col_index)) x_loaded[req.col_index] = 1'b1;
        if (req.op == OP_LOAD_Y && idx_valid(req.row_index)) y_loaded[req.row_index] = 1'b1;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic issue(input t_op op, input int row, input int col, input logic [31:0] val);
        t_item req;
        req.op        = op;
        req.row_index = IDX_W'(row);
        req.col_index = IDX_W'(col);
        req.value     = val;
        send_request(req);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_request(make_request());
        end
        no_gaps = 1'b0;
    endtask

    // Lets every queued request finish; requests without a result give no sign
    // of completion, hence the fixed tail.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input int len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= VLEN_W'(len);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = len;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length: extreme values and indices, rounding ties, product clamping.
        issue(OP_LOAD_X, 0, 0, 32'h7FFF_FFFF);
        issue(OP_LOAD_X, 0, 1023, 32'h8000_0000);
        issue(OP_LOAD_X, 0, 1, 32'h0000_8000);
        issue(OP_LOAD_Y, 0, 0, 32'h7FFF_FFFF);
        issue(OP_LOAD_Y, 1023, 0, 32'h8000_0000);
        issue(OP_LOAD_Y, 1, 0, 32'h0000_0000);
        issue(OP_ACCUM, 0, 0, 32'h7FFF_FFFF);
        issue(OP_ACCUM, 1023, 1023, 32'h8000_0000);
        issue(OP_ACCUM, 1, 1, 32'h0000_0001);
        issue(OP_ACCUM, 1, 1, 32'hFFFF_FFFF);
        issue(OP_ACCUM, 1, 1, 32'hFFFF_FFFD);
        issue(OP_ACCUM, 1, 1023, 32'h7FFF_FFFF);
        issue(OP_READ_Y, 0, 0, 32'h0);
        issue(OP_READ_Y, 1023, 1023, 32'hFFFF_FFFF);
        issue(OP_READ_Y, 1, 0, 32'h0);
        run_random(500);

        // Short vector: out-of-range cases, row reported first on a double error.
        settle();
        write_length(16);
        issue(OP_LOAD_X, 0, 16, 32'h1234_5678);
        issue(OP_LOAD_Y, 17, 0, 32'h0001_0000);
        issue(OP_ACCUM, 20, 30, 32'h0001_0000);
        issue(OP_ACCUM, 1, 16, 32'h0001_0000);
        issue(OP_LOAD_Y, 15, 0, 32'hFFFF_0000);
        issue(OP_READ_Y, 15, 0, 32'h0);
        issue(OP_READ_Y, 16, 0, 32'h0);
        run_random(150);

        settle();
        write_length(1);
        run_random(100);

        // A length of zero rejects every index.
        settle();
        write_length(0);
        run_random(30);

        settle();
        write_length(2047);
        run_random(150);

        settle();
        write_length($urandom_range(2, 1023));
        run_random(200);

        settle();
        write_length(1024);
        run_random(320);

        settle();
        if (model.n_fail == 0 && model.pending() == 0)
            $display("coo_sparse_matrix_vector_multiply_core_tb OK");
        else
            $display("coo_sparse_matrix_vector_multiply_core_tb NOT OK");
        $finish;
    end

endmodule
